[sv/hlx_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hlx_pkg
// Shared types and constants for the header / length / XOR frame sync block.
// -----------------------------------------------------------------------------
package hlx_pkg;

   // Default size of the receive buffer that bounds a frame.
   localparam int BUFFER_LIMIT_DEF = 2048;

   // Sync byte and header length.
   localparam logic [7:0] SYNC_BYTE = 8'hFE;
   localparam int HDR_LEN = 4;

   // Frame byte count at which the high and low length bytes have been taken.
   localparam int LEN_HIGH_COUNT = 6;
   localparam int LEN_LOW_COUNT  = 7;

   // Bytes added to the length field to give the frame total.
   localparam int TOTAL_EXTRA = 8;

   // Field widths.
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 11;
   localparam int TOTAL_W = 17;
   localparam int WIN_W   = 2;

   // Frame status codes.
   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_GOOD     = 2'd1,
      STATUS_CHECKSUM = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } frame_status_type;

   // One result item.
   typedef struct packed {
      logic [BYTE_W-1:0] byte_echo;
      logic              in_frame;
      logic              header_found;
      logic [POS_W-1:0]  byte_position;
      logic              frame_end;
      frame_status_type  frame_status;
      logic [POS_W-1:0]  frame_total;
   } result_type;

endpackage

[sv/hlx_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hlx_req_if / hlx_rsp_if
// Valid / ready channels for received bytes and per-byte results.
// -----------------------------------------------------------------------------
interface hlx_req_if;
   logic                      valid;
   logic                      ready;
   logic [hlx_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface hlx_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [hlx_pkg::BYTE_W-1:0] byte_echo;
   logic                      in_frame;
   logic                      header_found;
   logic [hlx_pkg::POS_W-1:0] byte_position;
   logic                      frame_end;
   logic [1:0]                frame_status;
   logic [hlx_pkg::POS_W-1:0] frame_total;

   modport source (output valid, output byte_echo, output in_frame, output header_found,
                   output byte_position, output frame_end, output frame_status,
                   output frame_total, input ready);
   modport sink   (input valid, input byte_echo, input in_frame, input header_found,
                   input byte_position, input frame_end, input frame_status,
                   input frame_total, output ready);
endinterface

[sv/header_length_xor_frame_sync.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// header_length_xor_frame_sync
// Byte-stream deframer: FE FE FE FE sync, big-endian length, XOR checksum.
// -----------------------------------------------------------------------------
// The block takes one byte per cycle while neither side stalls and returns
// one status result per byte, which passes through the input register and
// then the result register. Without stalls the sustained rate is one byte
// per clock, set by the deframer state update in hlx_core, which is
// combinational between its state registers. Either side may stall; while a
// finished result waits on the output, the input register can take one more
// byte and then holds the request side off. A frame starts after four sync
// bytes, carries its length in frame bytes 6 and 7 (big-endian, total is
// length plus 8) and ends good when the XOR of all its bytes is zero.
// -----------------------------------------------------------------------------
module header_length_xor_frame_sync #(
   parameter int BUFFER_LIMIT = hlx_pkg::BUFFER_LIMIT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hlx_req_if.sink   req_bus,
   hlx_rsp_if.source rsp_bus
);

   logic                       in_valid_ff;
   logic [hlx_pkg::BYTE_W-1:0] in_byte_ff;
   logic                       out_valid_ff;
   hlx_pkg::result_type        out_ff;
   hlx_pkg::result_type        core_result;
   logic                       advance;

   // A byte moves into the result register when that register is free.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.data_byte;
      end
   end

   hlx_core #(
      .BUFFER_LIMIT (BUFFER_LIMIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_byte_ff),
      .result    (core_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_result;
      end
   end

   // Drive the result channel.
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.byte_echo     = out_ff.byte_echo;
   assign rsp_bus.in_frame      = out_ff.in_frame;
   assign rsp_bus.header_found  = out_ff.header_found;
   assign rsp_bus.byte_position = out_ff.byte_position;
   assign rsp_bus.frame_end     = out_ff.frame_end;
   assign rsp_bus.frame_status  = out_ff.frame_status;
   assign rsp_bus.frame_total   = out_ff.frame_total;

endmodule

[sv/hlx_core.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hlx_core
// Deframer state and the combinational per-byte update: header hunt, byte count,
// length capture, XOR checksum and frame end decision.
// -----------------------------------------------------------------------------
module hlx_core #(
   parameter int BUFFER_LIMIT = hlx_pkg::BUFFER_LIMIT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  logic [hlx_pkg::BYTE_W-1:0]  data_byte,
   output hlx_pkg::result_type         result
);

   localparam int CNT_W = $clog2(BUFFER_LIMIT);
   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(BUFFER_LIMIT - 1);
   localparam logic [hlx_pkg::TOTAL_W-1:0] TOTAL_LIMIT =
      hlx_pkg::TOTAL_W'(BUFFER_LIMIT - 1);

   logic                          hunt_ff, hunt_in;
   logic [hlx_pkg::BYTE_W-1:0]    win_ff [4];
   logic [hlx_pkg::BYTE_W-1:0]    win_in [4];
   logic [hlx_pkg::BYTE_W-1:0]    win_mod [4];
   logic [hlx_pkg::WIN_W-1:0]     wc_ff, wc_in;
   logic [CNT_W-1:0]              fc_ff, fc_in, fc_new;
   logic [hlx_pkg::BYTE_W-1:0]    lh_ff, lh_in;
   logic [hlx_pkg::TOTAL_W-1:0]   exp_ff, exp_in;
   logic [hlx_pkg::BYTE_W-1:0]    xor_ff, xor_in;
   logic                          len_known;

   // Next state and result for the byte now being processed.
   always_comb begin
      hunt_in = hunt_ff;
      win_in  = win_ff;
      wc_in   = wc_ff;
      fc_in   = fc_ff;
      lh_in   = lh_ff;
      exp_in  = exp_ff;
      xor_in  = xor_ff;
      win_mod = win_ff;
      win_mod[wc_ff] = data_byte;
      fc_new    = fc_ff + CNT_W'(1);
      len_known = 1'b0;

      result.byte_echo     = data_byte;
      result.in_frame      = 1'b0;
      result.header_found  = 1'b0;
      result.byte_position = '0;
      result.frame_end     = 1'b0;
      result.frame_status  = hlx_pkg::STATUS_NONE;
      result.frame_total   = '0;

      if (hunt_ff) begin
         // Header hunt: fill the window, compare once it is full.
         result.byte_position = hlx_pkg::POS_W'(wc_ff);
         win_in = win_mod;
         if (wc_ff == hlx_pkg::WIN_W'(hlx_pkg::HDR_LEN - 1)) begin
            if (win_mod[0] == hlx_pkg::SYNC_BYTE && win_mod[1] == hlx_pkg::SYNC_BYTE &&
                win_mod[2] == hlx_pkg::SYNC_BYTE && win_mod[3] == hlx_pkg::SYNC_BYTE) begin
               result.header_found = 1'b1;
               hunt_in = 1'b0;
               fc_in   = CNT_W'(hlx_pkg::HDR_LEN);
               wc_in   = '0;
               xor_in  = '0;
            end else if (win_mod[1] == hlx_pkg::SYNC_BYTE) begin
               // Slide the window to start at the first sync byte after entry 0.
               win_in[0] = win_mod[1];
               win_in[1] = win_mod[2];
               win_in[2] = win_mod[3];
               wc_in     = 2'd3;
            end else if (win_mod[2] == hlx_pkg::SYNC_BYTE) begin
               win_in[0] = win_mod[2];
               win_in[1] = win_mod[3];
               wc_in     = 2'd2;
            end else if (win_mod[3] == hlx_pkg::SYNC_BYTE) begin
               win_in[0] = win_mod[3];
               wc_in     = 2'd1;
            end else begin
               wc_in = '0;
            end
         end else begin
            wc_in = wc_ff + hlx_pkg::WIN_W'(1);
         end
      end else begin
         // Inside a frame: count, checksum and pick up the length field.
         result.in_frame      = 1'b1;
         result.byte_position = hlx_pkg::POS_W'(fc_ff);
         fc_in  = fc_new;
         xor_in = xor_ff ^ data_byte;
         if (fc_new == CNT_W'(hlx_pkg::LEN_HIGH_COUNT)) begin
            lh_in = data_byte;
         end
         if (fc_new == CNT_W'(hlx_pkg::LEN_LOW_COUNT)) begin
            exp_in = hlx_pkg::TOTAL_W'({lh_ff, data_byte}) +
                     hlx_pkg::TOTAL_W'(hlx_pkg::TOTAL_EXTRA);
         end
         len_known = (fc_new >= CNT_W'(hlx_pkg::LEN_LOW_COUNT));
         if (len_known) begin
            result.frame_total = hlx_pkg::POS_W'(exp_in);
         end

         // Frame end: length overflow, count overflow, or normal end.
         if (fc_new == CNT_W'(hlx_pkg::LEN_LOW_COUNT) && exp_in >= TOTAL_LIMIT) begin
            result.frame_end    = 1'b1;
            result.frame_status = hlx_pkg::STATUS_OVERFLOW;
            hunt_in = 1'b1;
         end else if (fc_new >= COUNT_LIMIT) begin
            result.frame_end    = 1'b1;
            result.frame_status = hlx_pkg::STATUS_OVERFLOW;
            hunt_in = 1'b1;
         end else if (len_known && hlx_pkg::TOTAL_W'(fc_new) == exp_in) begin
            result.frame_end    = 1'b1;
            result.frame_status = (xor_in == '0) ? hlx_pkg::STATUS_GOOD
                                                 : hlx_pkg::STATUS_CHECKSUM;
            hunt_in = 1'b1;
         end
      end
   end

   // State registers, updated once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff <= 1'b1;
         win_ff  <= '{default: '0};
         wc_ff   <= '0;
         fc_ff   <= '0;
         lh_ff   <= '0;
         exp_ff  <= '0;
         xor_ff  <= '0;
      end else if (step_en) begin
         hunt_ff <= hunt_in;
         win_ff  <= win_in;
         wc_ff   <= wc_in;
         fc_ff   <= fc_in;
         lh_ff   <= lh_in;
         exp_ff  <= exp_in;
         xor_ff  <= xor_in;
      end
   end

endmodule

[sv/hlx_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hlx_checker
// Port-level checks on the frame sync results, bound to the top level.
// -----------------------------------------------------------------------------
module hlx_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       in_frame,
   input logic                       header_found,
   input logic [hlx_pkg::POS_W-1:0]  byte_position,
   input logic                       frame_end,
   input logic [1:0]                 frame_status,
   input logic [hlx_pkg::POS_W-1:0]  frame_total,
   input logic [hlx_pkg::BYTE_W-1:0] byte_echo
);

   // A header match is the last byte of the window and never inside a frame.
   a_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && header_found |-> !in_frame && !frame_end &&
         byte_position == hlx_pkg::POS_W'(hlx_pkg::HDR_LEN - 1) && frame_total == '0)
      else $error("header result with inconsistent fields");

   // A frame end always carries a status, and a status only comes with a frame end.
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> frame_end == (frame_status != hlx_pkg::STATUS_NONE))
      else $error("frame end and status disagree");

   // While hunting there is no frame total and no frame end.
   a_hunt_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !in_frame |-> frame_total == '0 && !frame_end)
      else $error("frame fields set outside a frame");

   // A normal frame end falls on the last byte of the stated total.
   a_end_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_end && (frame_status == hlx_pkg::STATUS_GOOD ||
         frame_status == hlx_pkg::STATUS_CHECKSUM) |->
         hlx_pkg::POS_W'(byte_position + hlx_pkg::POS_W'(1)) == frame_total)
      else $error("frame end not on last byte");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(byte_echo) &&
         $stable(byte_position) && $stable(frame_status))
      else $error("stalled result changed");

endmodule

bind header_length_xor_frame_sync hlx_checker u_hlx_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .in_frame      (rsp_bus.in_frame),
   .header_found  (rsp_bus.header_found),
   .byte_position (rsp_bus.byte_position),
   .frame_end     (rsp_bus.frame_end),
   .frame_status  (rsp_bus.frame_status),
   .frame_total   (rsp_bus.frame_total),
   .byte_echo     (rsp_bus.byte_echo)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FE FE FE FE / length / XOR frame sync block.
// -----------------------------------------------------------------------------
// Bytes are sent on the request channel and every transfer is fed to a
// behavioural tracker of the deframer, which predicts the status result the
// byte should produce. Each result transfer is checked, field by field,
// against the oldest prediction. The stimulus opens with a few hand-built
// frames, then mixes well-formed frames of random content with spoiled
// checksums, oversized lengths, sync noise and broken headers. Both channels
// stall at random, apart from one stretch of full-rate traffic.
// -----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_ITEMS = 1400;
   localparam int STALL_LIMIT  = 2000;
   localparam int IDLE_PERCENT = 28;
   localparam int REPORT_LIMIT = 10;
   // Lengths from here upward give a total that overflows the buffer.
   localparam int OVERFLOW_LEN = hlx_pkg::BUFFER_LIMIT_DEF - 1 - hlx_pkg::TOTAL_EXTRA;

   // Behavioural tracker of the deframer and store of predicted results.
   class frame_tracker;
      bit                   hunting = 1'b1;
      bit [7:0]             window [hlx_pkg::HDR_LEN];
      int unsigned          window_fill;
      int unsigned          frame_count;
      bit [7:0]             len_high;
      bit [16:0]            total_full;
      bit [7:0]             xor_acc;
      hlx_pkg::result_type  expected_status [$];
      int unsigned          failures;

      function int unsigned pending();
         return expected_status.size();
      endfunction

      function string describe(hlx_pkg::result_type r);
         return $sformatf("byte=%h in_frame=%b hdr=%b pos=%0d end=%b status=%0d total=%0d",
                          r.byte_echo, r.in_frame, r.header_found, r.byte_position,
                          r.frame_end, r.frame_status, r.frame_total);
      endfunction

      // Advance the deframer by one transferred byte and queue its result.
      function void take_byte(bit [7:0] b);
         hlx_pkg::result_type r;
         int unsigned         skip;
         r = '0;
         r.byte_echo = b;
         r.frame_status = hlx_pkg::STATUS_NONE;
         if (hunting) begin
            r.byte_position = 11'(window_fill);
            window[window_fill] = b;
            window_fill++;
            if (window_fill == hlx_pkg::HDR_LEN) begin
               if (window[0] == hlx_pkg::SYNC_BYTE && window[1] == hlx_pkg::SYNC_BYTE &&
                   window[2] == hlx_pkg::SYNC_BYTE && window[3] == hlx_pkg::SYNC_BYTE) begin
                  r.header_found = 1'b1;
                  hunting = 1'b0;
                  frame_count = hlx_pkg::HDR_LEN;
                  window_fill = 0;
                  xor_acc = '0;
               end else begin
                  // Realign the window on the next sync byte after its first entry.
                  skip = 1;
                  while (skip < hlx_pkg::HDR_LEN && window[skip] != hlx_pkg::SYNC_BYTE)
                     skip++;
                  for (int j = 0; j + skip < hlx_pkg::HDR_LEN; j++)
                     window[j] = window[j + skip];
                  window_fill = hlx_pkg::HDR_LEN - skip;
               end
            end
         end else begin
            r.in_frame = 1'b1;
            r.byte_position = 11'(frame_count);
            frame_count++;
            xor_acc ^= b;
            if (frame_count == hlx_pkg::LEN_HIGH_COUNT)
               len_high = b;
            if (frame_count == hlx_pkg::LEN_LOW_COUNT)
               total_full = 17'({len_high, b}) + 17'(hlx_pkg::TOTAL_EXTRA);
            if (frame_count >= hlx_pkg::LEN_LOW_COUNT)
               r.frame_total = total_full[hlx_pkg::POS_W-1:0];
            // Oversized length, runaway count, or a regular frame end.
            if (frame_count == hlx_pkg::LEN_LOW_COUNT &&
                total_full >= hlx_pkg::BUFFER_LIMIT_DEF - 1) begin
               r.frame_end = 1'b1;
               r.frame_status = hlx_pkg::STATUS_OVERFLOW;
               hunting = 1'b1;
            end else if (frame_count >= hlx_pkg::BUFFER_LIMIT_DEF - 1) begin
               r.frame_end = 1'b1;
               r.frame_status = hlx_pkg::STATUS_OVERFLOW;
               hunting = 1'b1;
            end else if (frame_count >= hlx_pkg::LEN_LOW_COUNT &&
                         frame_count == total_full) begin
               r.frame_end = 1'b1;
               r.frame_status = (xor_acc == 0) ? hlx_pkg::STATUS_GOOD
                                               : hlx_pkg::STATUS_CHECKSUM;
               hunting = 1'b1;
            end
         end
         expected_status.push_back(r);
      endfunction

      // Compare one result transfer with the oldest prediction.
      function void check_status(hlx_pkg::result_type got);
         hlx_pkg::result_type want;
         if (expected_status.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: %s", describe(got));
            return;
         end
         want = expected_status.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("mismatch at %0t", $realtime);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   hlx_req_if req_bus ();
   hlx_rsp_if rsp_bus ();

   header_length_xor_frame_sync dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   frame_tracker tracker = new;
   bit           no_idle = 1'b0;
   int unsigned  bytes_sent;
   int unsigned  stalled_cycles;

   // Clock generation.
   always #2 clock = ~clock;

   // Result channel back-pressure.
   always @(posedge clock) begin
      rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Observe transfers on both channels and watch for a hang.
   always @(posedge clock) begin
      hlx_pkg::result_type got;
      bit                  moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            tracker.take_byte(req_bus.data_byte);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.byte_echo     = rsp_bus.byte_echo;
            got.in_frame      = rsp_bus.in_frame;
            got.header_found  = rsp_bus.header_found;
            got.byte_position = rsp_bus.byte_position;
            got.frame_end     = rsp_bus.frame_end;
            got.frame_status  = hlx_pkg::frame_status_type'(rsp_bus.frame_status);
            got.frame_total   = rsp_bus.frame_total;
            tracker.check_status(got);
            moved = 1'b1;
         end
      end
      stalled_cycles = moved ? 0 : stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one byte, with random idle cycles ahead of it, until it is taken.
   task automatic send_byte(input logic [7:0] b);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // Send a header and frame body; for len below OVERFLOW_LEN the body XORs to zero
   // unless spoilt. The length sits in the second and third body bytes.
   task automatic send_frame(input int unsigned len, input bit spoil);
      logic [7:0]  body [$];
      logic [7:0]  acc;
      int unsigned k;
      body = {8'($urandom), 8'(len >> 8), 8'(len), 8'($urandom)};
      repeat (hlx_pkg::HDR_LEN) send_byte(hlx_pkg::SYNC_BYTE);
      if (len < OVERFLOW_LEN) begin
         repeat (len) body.push_back(8'($urandom));
         acc = '0;
         foreach (body[i])
            acc ^= body[i];
         body[body.size() - 1] ^= acc;
         // Corrupt a byte other than the two length bytes.
         if (spoil) begin
            k = $urandom_range(0, len + 1);
            if (k >= 1)
               k += 2;
            body[k] ^= 8'($urandom_range(1, 255));
         end
      end
      foreach (body[i])
         send_byte(body[i]);
   endtask

   // Random bytes rich in sync values.
   task automatic send_noise();
      repeat ($urandom_range(1, 6))
         send_byte(($urandom_range(0, 99) < 40) ? hlx_pkg::SYNC_BYTE : 8'($urandom));
   endtask

   // A short run of sync bytes broken by some other value.
   task automatic send_broken_header();
      logic [7:0] b;
      repeat ($urandom_range(1, 3)) send_byte(hlx_pkg::SYNC_BYTE);
      do
         b = 8'($urandom);
      while (b == hlx_pkg::SYNC_BYTE);
      send_byte(b);
   endtask

   // Hold the request channel idle until every predicted result has arrived.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   // Main stimulus sequence.
   initial begin
      int unsigned frame_no;
      int          pick;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: shortest good frame, spoilt checksum, largest length field,
      // then sync noise that leaves a partly filled window.
      send_frame(0, 1'b0);
      send_frame(1, 1'b1);
      send_frame(16'hFFFF, 1'b0);
      send_byte(8'h00);
      send_byte(hlx_pkg::SYNC_BYTE);
      send_byte(8'hFF);
      send_byte(8'h7F);
      wait_for_drain();

      // Random traffic, mostly well-formed frames.
      bytes_sent = 0;
      frame_no = 0;
      while (bytes_sent < RANDOM_ITEMS) begin
         no_idle = (bytes_sent >= 500 && bytes_sent < 800);
         pick = $urandom_range(0, 99);
         if (frame_no == 10) begin
            // Smallest length that overflows the buffer.
            send_frame(OVERFLOW_LEN, 1'b0);
            frame_no++;
         end else if (pick < 65) begin
            send_frame($urandom_range(0, 24), $urandom_range(0, 3) == 0);
            frame_no++;
         end else if (pick < 77) begin
            send_noise();
         end else if (pick < 88) begin
            send_broken_header();
         end else if (pick < 95) begin
            send_frame($urandom_range(OVERFLOW_LEN, 16'hFFFF), 1'b0);
            frame_no++;
         end else begin
            // Header with a cut-off body; later bytes run on as frame bytes.
            repeat (hlx_pkg::HDR_LEN) send_byte(hlx_pkg::SYNC_BYTE);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
         end
      end
      no_idle = 1'b0;
      req_bus.valid <= 1'b0;

      // Drain the remaining results, then allow for the pipeline depth.
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
